// ----- rtl/core/dbpc_pkg.sv -----
// ---------------------------------------------------------------------------
// dbpc_pkg
// Shared types and constants of the debounced button press classifier:
// register indexes, event codes, counter widths and the state record.
// ---------------------------------------------------------------------------
`default_nettype none

package dbpc_pkg;

   localparam int unsigned CfgWidth    = 16;
   localparam int unsigned IndexWidth  = 3;
   localparam int unsigned SteadyWidth = 16;
   localparam int unsigned HoldWidth   = 18;
   localparam int unsigned RemindWidth = 17;

   // register indexes on the csr port
   localparam logic [IndexWidth-1:0] RegDebounce   = 3'd0;
   localparam logic [IndexWidth-1:0] RegSelectHold = 3'd1;
   localparam logic [IndexWidth-1:0] RegSleepArm   = 3'd2;
   localparam logic [IndexWidth-1:0] RegTooLong    = 3'd3;
   localparam logic [IndexWidth-1:0] RegRemind     = 3'd4;

   localparam logic [CfgWidth-1:0] DebounceReset   = 16'd30;
   localparam logic [CfgWidth-1:0] SelectHoldReset = 16'd600;
   localparam logic [CfgWidth-1:0] SleepArmReset   = 16'd5000;
   localparam logic [CfgWidth-1:0] TooLongReset    = 16'd5000;
   localparam logic [CfgWidth-1:0] RemindReset     = 16'd2500;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_NEXT     = 3'd1,
      EV_SELECT   = 3'd2,
      EV_SLEEP    = 3'd3,
      EV_ARMED    = 3'd4,
      EV_ABORTED  = 3'd5,
      EV_CANCELED = 3'd6,
      EV_REMIND   = 3'd7
   } event_type;

   typedef struct packed {
      logic [CfgWidth-1:0] settle_ms;
      logic [CfgWidth-1:0] select_hold_ms;
      logic [CfgWidth-1:0] arm_hold_ms;
      logic [CfgWidth-1:0] abort_extra_ms;
      logic [CfgWidth-1:0] nag_gap_ms;
   } cfg_type;

   typedef struct packed {
      logic                   last_raw;
      logic [SteadyWidth-1:0] steady_count;
      logic                   stable_level;
      logic                   press_active;
      logic [HoldWidth-1:0]   hold_count;
      logic                   armed_flag;
      logic                   aborted_flag;
      logic [RemindWidth-1:0] reminder_count;
   } state_type;

   typedef struct packed {
      event_type event_res;
      logic      stable_pressed_out;
      logic      armed_out;
      logic      aborted_out;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/core/debounced_button_press_classifier.sv -----
// ---------------------------------------------------------------------------
// debounced_button_press_classifier
// Debounces one button sample per tick, times presses and reports next,
// select, sleep request, armed, aborted, canceled and reminder events.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   req     | req_valid/req_ready, raw_pressed    | in
//   rsp     | rsp_valid/rsp_ready, event + flags  | out
//   csr     | csr_we, csr_index, csr_wdata        | in
//
// Each sample gives exactly one result. A sample is held in the input
// register, is evaluated against the state registers and lands in the result
// register; one sample per cycle is sustained while rsp_ready stays high.
// The state update is a single pass of counter compares.
// A stalled result register holds the input register, which then stalls req.
// Reset clears all state and loads the default thresholds.
// ---------------------------------------------------------------------------
`default_nettype none

module debounced_button_press_classifier (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_raw_pressed,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [2:0]                           rsp_event_res,
   output logic                                 rsp_stable_pressed_out,
   output logic                                 rsp_armed_out,
   output logic                                 rsp_aborted_out,
   input  wire logic                            csr_we,
   input  wire logic [dbpc_pkg::IndexWidth-1:0] csr_index,
   input  wire logic [dbpc_pkg::CfgWidth-1:0]   csr_wdata
);

   dbpc_pkg::cfg_type    cfg;
   dbpc_pkg::state_type  state_ff;
   dbpc_pkg::state_type  state_in;
   dbpc_pkg::result_type step_res;
   dbpc_pkg::result_type res_ff;

   logic in_vld_ff;
   logic raw_ff;
   logic out_vld_ff;
   logic advance;

   dbpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dbpc_step u_step (
      .cur (state_ff),
      .cfg (cfg),
      .raw (raw_ff),
      .nxt (state_in),
      .res (step_res)
   );

   // evaluate the held sample when the result register is free
   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         raw_ff <= req_raw_pressed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= step_res;
      end
   end

   assign rsp_valid              = out_vld_ff;
   assign rsp_event_res          = res_ff.event_res;
   assign rsp_stable_pressed_out = res_ff.stable_pressed_out;
   assign rsp_armed_out          = res_ff.armed_out;
   assign rsp_aborted_out        = res_ff.aborted_out;

endmodule

`default_nettype wire

// ----- rtl/core/dbpc_csr.sv -----
// ---------------------------------------------------------------------------
// dbpc_csr
// Configuration registers: five 16-bit thresholds written by index.
// ---------------------------------------------------------------------------
`default_nettype none

module dbpc_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [dbpc_pkg::IndexWidth-1:0]    csr_index,
   input  wire logic [dbpc_pkg::CfgWidth-1:0]      csr_wdata,
   output dbpc_pkg::cfg_type                       cfg
);

   dbpc_pkg::cfg_type cfg_ff;
   dbpc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            dbpc_pkg::RegDebounce:   cfg_in.settle_ms      = csr_wdata;
            dbpc_pkg::RegSelectHold: cfg_in.select_hold_ms = csr_wdata;
            dbpc_pkg::RegSleepArm:   cfg_in.arm_hold_ms    = csr_wdata;
            dbpc_pkg::RegTooLong:    cfg_in.abort_extra_ms = csr_wdata;
            dbpc_pkg::RegRemind:     cfg_in.nag_gap_ms     = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ms      <= dbpc_pkg::DebounceReset;
         cfg_ff.select_hold_ms <= dbpc_pkg::SelectHoldReset;
         cfg_ff.arm_hold_ms    <= dbpc_pkg::SleepArmReset;
         cfg_ff.abort_extra_ms <= dbpc_pkg::TooLongReset;
         cfg_ff.nag_gap_ms     <= dbpc_pkg::RemindReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/core/dbpc_step.sv -----
// ---------------------------------------------------------------------------
// dbpc_step
// One tick of the classifier: counters, debounce, release decode and the
// arm / abort / reminder checks, all combinational.
// ---------------------------------------------------------------------------
`default_nettype none

module dbpc_step (
   input  wire dbpc_pkg::state_type cur,
   input  wire dbpc_pkg::cfg_type   cfg,
   input  wire logic                raw,
   output dbpc_pkg::state_type      nxt,
   output dbpc_pkg::result_type     res
);

   logic                                hold_run;
   logic [dbpc_pkg::HoldWidth-1:0]      hold_adv;
   logic [dbpc_pkg::RemindWidth-1:0]    rem_adv;
   logic [dbpc_pkg::HoldWidth-1:0]      held;
   logic [dbpc_pkg::RemindWidth-1:0]    abort_limit;
   logic                                level_change;
   logic                                release_ev;
   logic                                armed_now;
   logic                                aborted_now;
   logic                                remind_now;
   dbpc_pkg::event_type                 ev;

   assign abort_limit = {1'b0, cfg.arm_hold_ms} + {1'b0, cfg.abort_extra_ms};

   always_comb begin
      nxt         = cur;
      ev          = dbpc_pkg::EV_NONE;
      release_ev  = 1'b0;
      armed_now   = 1'b0;
      aborted_now = 1'b0;
      remind_now  = 1'b0;
      held        = '0;

      // advance running counters, saturating
      hold_run = cur.press_active && cur.stable_level && (cur.hold_count != '1);
      hold_adv = hold_run ? cur.hold_count + 1'b1 : cur.hold_count;
      rem_adv  = (cur.armed_flag && !cur.aborted_flag && (cur.reminder_count != '1))
                 ? cur.reminder_count + 1'b1 : cur.reminder_count;
      nxt.hold_count     = hold_adv;
      nxt.reminder_count = rem_adv;

      // debounce
      if (raw != cur.last_raw) begin
         nxt.last_raw     = raw;
         nxt.steady_count = '0;
      end else if (cur.steady_count != '1) begin
         nxt.steady_count = cur.steady_count + 1'b1;
      end

      level_change = (nxt.steady_count >= cfg.settle_ms) && (raw != cur.stable_level);

      if (level_change) begin
         nxt.stable_level = raw;
         if (!raw) begin
            held = cur.press_active ? hold_adv : '0;
            if (cur.armed_flag && !cur.aborted_flag) begin
               ev = dbpc_pkg::EV_SLEEP;
            end else if (cur.armed_flag) begin
               ev = dbpc_pkg::EV_CANCELED;
            end else if (held >= {2'b00, cfg.select_hold_ms}) begin
               ev = dbpc_pkg::EV_SELECT;
            end else if (held != '0) begin
               ev = dbpc_pkg::EV_NEXT;
            end
            release_ev = 1'b1;
         end
         // clear press state on both edges; a press starts fresh
         nxt.press_active   = raw;
         nxt.hold_count     = '0;
         nxt.armed_flag     = 1'b0;
         nxt.aborted_flag   = 1'b0;
         nxt.reminder_count = '0;
      end

      if (!release_ev && nxt.stable_level && nxt.press_active) begin
         if (!nxt.armed_flag && (nxt.hold_count >= {2'b00, cfg.arm_hold_ms})) begin
            nxt.armed_flag     = 1'b1;
            nxt.aborted_flag   = 1'b0;
            nxt.reminder_count = '0;
            armed_now          = 1'b1;
         end
         if (nxt.armed_flag && !nxt.aborted_flag &&
             (nxt.hold_count >= {1'b0, abort_limit})) begin
            nxt.aborted_flag = 1'b1;
            aborted_now      = 1'b1;
         end
         if (nxt.armed_flag && !nxt.aborted_flag &&
             (nxt.reminder_count > {1'b0, cfg.nag_gap_ms})) begin
            nxt.reminder_count = '0;
            remind_now         = 1'b1;
         end
         if (aborted_now) begin
            ev = dbpc_pkg::EV_ABORTED;
         end else if (armed_now) begin
            ev = dbpc_pkg::EV_ARMED;
         end else if (remind_now) begin
            ev = dbpc_pkg::EV_REMIND;
         end
      end

      res.event_res          = ev;
      res.stable_pressed_out = nxt.stable_level;
      res.armed_out          = nxt.armed_flag;
      res.aborted_out        = nxt.aborted_flag;
   end

endmodule

`default_nettype wire
